[rtl/core/exit_reason_histogram_top_k_assert.svh]
// ----------------------------------------------------------------------------
// Exit reason histogram assertion macros
// Shared forms for the concurrent assertions of the histogram block.
// ----------------------------------------------------------------------------
`ifndef EXIT_REASON_HISTOGRAM_TOP_K_ASSERT_SVH
`define EXIT_REASON_HISTOGRAM_TOP_K_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EXH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define EXH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/exh_pkg.sv]
// ----------------------------------------------------------------------------
// Exit reason histogram package
// Field widths, operation codes, defaults and the ranker control type.
// ----------------------------------------------------------------------------
package exh_pkg;

  localparam int NUM_REASONS_DEF = 256;
  localparam int TOP_MAX_DEF     = 8;
  localparam int COUNT_WIDTH_DEF = 48;

  localparam int MODE_W       = 3;
  localparam int REASON_W     = 16;
  localparam int TOP_COUNT_W  = 4;
  localparam int REASON_OUT_W = 8;
  localparam int EVENT_W      = 48;

  localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ONE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOP       = 3'd4;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } rank_ctl_t;

endpackage

[rtl/core/exit_reason_histogram_top_k.sv]
// ----------------------------------------------------------------------------
// Exit reason histogram with top-k report
// Saturating event counters per exit reason held in one synchronous memory,
// with single reads, clears and a ranked top-k report.
// ----------------------------------------------------------------------------
// After reset and after every clear-all the block sweeps the counter memory,
// one entry a cycle, and takes no input beat until the sweep ends. A count
// beat reads the counter, then writes it back; a clear-one beat writes in
// the cycle it is taken, and a read beat reads into the read register and
// then moves the result into the output register. A top beat reads every
// counter through the single memory port, then reports the ranked entries
// one after another, holding while the output side stalls. The next input
// beat may be taken while the last result still waits in the output register.
module exit_reason_histogram_top_k #(
  parameter int NUM_REASONS = exh_pkg::NUM_REASONS_DEF,
  parameter int TOP_MAX     = exh_pkg::TOP_MAX_DEF,
  parameter int COUNT_WIDTH = exh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [exh_pkg::MODE_W-1:0]       in_mode,
  input  logic [exh_pkg::REASON_W-1:0]     in_reason,
  input  logic [exh_pkg::TOP_COUNT_W-1:0]  in_top_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [exh_pkg::REASON_OUT_W-1:0] out_reason_out,
  output logic [exh_pkg::EVENT_W-1:0]      out_event_count,
  output logic                             out_last
);

  localparam int RW = $clog2(NUM_REASONS);
  localparam int KW = $clog2(TOP_MAX + 1);
  localparam logic [RW-1:0] LastIdx = RW'(NUM_REASONS - 1);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_INC, ST_RD, ST_SCAN, ST_DRAIN, ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [RW-1:0]          scan_r;
  logic [RW-1:0]          idx_r;
  logic                   in_range_r;
  logic [exh_pkg::REASON_OUT_W-1:0] echo_r;
  logic [KW-1:0]          k_r;
  logic [KW-1:0]          rem_r;
  logic                   ins_v_r;
  logic [RW-1:0]          ins_reason_r;
  logic                   out_valid_r;
  logic [exh_pkg::REASON_OUT_W-1:0] out_reason_r;
  logic [exh_pkg::EVENT_W-1:0]      out_count_r;
  logic                   out_last_r;

  logic [COUNT_WIDTH-1:0] mem [NUM_REASONS];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  logic                   in_acc;
  logic [RW-1:0]          in_idx;
  logic                   in_range;
  logic [KW-1:0]          k_in;
  logic                   out_free;
  logic                   out_load;
  logic                   rd_en;
  logic [RW-1:0]          rd_addr;
  logic                   wr_en;
  logic [RW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  exh_pkg::rank_ctl_t     rctl;
  logic [COUNT_WIDTH-1:0] head_count;
  logic [RW-1:0]          head_reason;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_idx   = in_reason[RW-1:0];
  assign in_range = (32'(in_reason) < NUM_REASONS);
  assign k_in     = (32'(in_top_count) > TOP_MAX) ? KW'(TOP_MAX) : KW'(in_top_count);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == ST_RD) || (state_r == ST_EMIT));

  assign rd_en   = in_acc || (state_r == ST_SCAN);
  assign rd_addr = (state_r == ST_SCAN) ? scan_r : in_idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_r;
    wr_data = '0;
    unique case (state_r)
      ST_CLR: begin
        wr_en = 1'b1;
      end
      ST_INC: begin
        wr_en   = in_range_r;
        wr_addr = idx_r;
        wr_data = (rd_data_r == '1) ? rd_data_r : rd_data_r + COUNT_WIDTH'(1);
      end
      ST_IDLE: begin
        wr_en   = in_acc && (in_mode == exh_pkg::MODE_CLEAR_ONE) && in_range;
        wr_addr = in_idx;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    rctl.clear  = in_acc && (in_mode == exh_pkg::MODE_TOP) && (k_in != '0);
    rctl.insert = ins_v_r;
    rctl.shift  = (state_r == ST_EMIT) && out_free;
  end

  exh_ranker #(
    .TOP_MAX    (TOP_MAX),
    .COUNT_WIDTH(COUNT_WIDTH),
    .RW         (RW),
    .KW         (KW)
  ) u_ranker (
    .clk        (clk),
    .ctl        (rctl),
    .k          (k_r),
    .ins_count  (rd_data_r),
    .ins_reason (ins_reason_r),
    .head_count (head_count),
    .head_reason(head_reason)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      scan_r      <= '0;
      ins_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      rem_r       <= '0;
    end else begin
      ins_v_r      <= (state_r == ST_SCAN);
      ins_reason_r <= scan_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          if (scan_r == LastIdx) begin
            scan_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            scan_r <= scan_r + RW'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            idx_r      <= in_idx;
            in_range_r <= in_range;
            echo_r     <= in_reason[exh_pkg::REASON_OUT_W-1:0];
            unique case (in_mode)
              exh_pkg::MODE_COUNT: state_r <= ST_INC;
              exh_pkg::MODE_READ:  state_r <= ST_RD;
              exh_pkg::MODE_CLEAR_ALL: begin
                scan_r  <= '0;
                state_r <= ST_CLR;
              end
              exh_pkg::MODE_TOP: begin
                if (k_in != '0) begin
                  k_r     <= k_in;
                  rem_r   <= k_in;
                  scan_r  <= '0;
                  state_r <= ST_SCAN;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_INC: begin
          state_r <= ST_IDLE;
        end
        ST_RD: begin
          if (out_free) begin
            out_reason_r <= echo_r;
            out_count_r  <= in_range_r ? exh_pkg::EVENT_W'(rd_data_r) : '0;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_r == LastIdx) begin
            scan_r  <= '0;
            state_r <= ST_DRAIN;
          end else begin
            scan_r <= scan_r + RW'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_reason_r <= exh_pkg::REASON_OUT_W'(head_reason);
            out_count_r  <= exh_pkg::EVENT_W'(head_count);
            out_last_r   <= (rem_r == KW'(1));
            rem_r        <= rem_r - KW'(1);
            if (rem_r == KW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reason_out  = out_reason_r;
  assign out_event_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

[rtl/core/exh_ranker.sv]
// ----------------------------------------------------------------------------
// Exit reason histogram ranker
// Sorted row of count cells that takes one candidate per cycle and shifts
// its head out during the report.
// ----------------------------------------------------------------------------
module exh_ranker #(
  parameter int TOP_MAX     = exh_pkg::TOP_MAX_DEF,
  parameter int COUNT_WIDTH = exh_pkg::COUNT_WIDTH_DEF,
  parameter int RW          = 8,
  parameter int KW          = $clog2(TOP_MAX + 1)
) (
  input  logic                   clk,
  input  exh_pkg::rank_ctl_t     ctl,
  input  logic [KW-1:0]          k,
  input  logic [COUNT_WIDTH-1:0] ins_count,
  input  logic [RW-1:0]          ins_reason,
  output logic [COUNT_WIDTH-1:0] head_count,
  output logic [RW-1:0]          head_reason
);

  logic [COUNT_WIDTH-1:0] cnt_r [TOP_MAX];
  logic [RW-1:0]          rsn_r [TOP_MAX];
  logic [TOP_MAX-1:0]     gt;

  always_comb begin
    for (int i = 0; i < TOP_MAX; i++) begin
      gt[i] = (KW'(i) < k) && (ins_count > cnt_r[i]);
    end
  end

  for (genvar g = 0; g < TOP_MAX; g++) begin : g_cell
    logic [COUNT_WIDTH-1:0] prev_cnt;
    logic [RW-1:0]          prev_rsn;
    logic                   prev_gt;
    logic [COUNT_WIDTH-1:0] next_cnt;
    logic [RW-1:0]          next_rsn;

    if (g == 0) begin : g_first
      assign prev_cnt = '0;
      assign prev_rsn = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_rest
      assign prev_cnt = cnt_r[g-1];
      assign prev_rsn = rsn_r[g-1];
      assign prev_gt  = gt[g-1];
    end

    if (g == TOP_MAX - 1) begin : g_tail
      assign next_cnt = '0;
      assign next_rsn = '0;
    end else begin : g_body
      assign next_cnt = cnt_r[g+1];
      assign next_rsn = rsn_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.clear) begin
        cnt_r[g] <= '0;
        rsn_r[g] <= '0;
      end else if (ctl.insert && gt[g]) begin
        cnt_r[g] <= prev_gt ? prev_cnt : ins_count;
        rsn_r[g] <= prev_gt ? prev_rsn : ins_reason;
      end else if (ctl.shift) begin
        cnt_r[g] <= next_cnt;
        rsn_r[g] <= next_rsn;
      end
    end
  end

  assign head_count  = cnt_r[0];
  assign head_reason = rsn_r[0];

endmodule

[rtl/core/exh_check.sv]
// ----------------------------------------------------------------------------
// Exit reason histogram port checker
// Watches the top level's ports and flags sequencing slips over time.
// ----------------------------------------------------------------------------
`include "exit_reason_histogram_top_k_assert.svh"

module exh_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [exh_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_last
);

  logic in_beat;
  logic out_beat;
  logic count_beat;
  logic read_beat;
  logic wipe_beat;

  assign in_beat    = in_valid && !in_stall;
  assign out_beat   = out_valid && !out_stall;
  assign count_beat = in_beat && (in_mode == exh_pkg::MODE_COUNT);
  assign read_beat  = in_beat && (in_mode == exh_pkg::MODE_READ);
  assign wipe_beat  = in_beat && (in_mode == exh_pkg::MODE_CLEAR_ALL);

  `EXH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Stalled result was dropped.")
  `EXH_ASSERT_NEXT(a_count_busy, count_beat, in_stall, "Count beat did not stall the input.")
  `EXH_ASSERT_NEXT(a_read_busy, read_beat, in_stall, "Read beat did not stall the input.")
  `EXH_ASSERT_NEXT(a_clear_busy, wipe_beat, in_stall, "Clear-all beat did not start the sweep.")
  `EXH_ASSERT_SAME(a_report_busy, out_beat && !out_last, in_stall, "Input taken during a report.")

endmodule

bind exit_reason_histogram_top_k exh_check u_exh_check (.*);

[verif/exit_reason_histogram_top_k_test.sv]
// ----------------------------------------------------------------------------
// Exit reason histogram testbench
// Drives directed and random count, read, clear and top-k beats into the
// histogram under random sender gaps and receiver stalls. Every result beat
// is checked against the directed table or a model of the counters and ranking.
// ----------------------------------------------------------------------------
module exit_reason_histogram_top_k_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOT_POOL_SIZE  = 10;
  localparam int DIRECTED_ROWS  = 25;

  localparam logic [exh_pkg::MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [exh_pkg::MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [exh_pkg::REASON_OUT_W-1:0] reason;
    logic [exh_pkg::EVENT_W-1:0]      count;
    logic                             is_last;
  } result_beat_t;

  typedef struct packed {
    logic [exh_pkg::MODE_W-1:0]       mode;
    logic [exh_pkg::REASON_W-1:0]     reason;
    logic [exh_pkg::TOP_COUNT_W-1:0]  top;
    logic                             typed;
    logic [exh_pkg::REASON_OUT_W-1:0] exp_reason;
    logic [exh_pkg::EVENT_W-1:0]      exp_count;
  } directed_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [exh_pkg::MODE_W-1:0]        in_mode;
  logic [exh_pkg::REASON_W-1:0]      in_reason;
  logic [exh_pkg::TOP_COUNT_W-1:0]   in_top_count;
  logic                              out_valid;
  logic                              out_stall;
  logic [exh_pkg::REASON_OUT_W-1:0]  out_reason_out;
  logic [exh_pkg::EVENT_W-1:0]       out_event_count;
  logic                              out_last;

  logic [exh_pkg::COUNT_WIDTH_DEF-1:0] reason_tally [exh_pkg::NUM_REASONS_DEF];
  logic [7:0]                          hot_pool [HOT_POOL_SIZE];
  result_beat_t                        pending_results [$];
  result_beat_t                        oldest;
  int                                  err_count;
  int                                  idle_cycles;
  int                                  send_idle_pct;
  int                                  recv_stall_pct;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{exh_pkg::MODE_READ,      16'd0,     4'd0,  1'b1, 8'd0,   48'd0},
    '{exh_pkg::MODE_READ,      16'd255,   4'd0,  1'b1, 8'd255, 48'd0},
    '{exh_pkg::MODE_TOP,       16'd0,     4'd8,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_TOP,       16'd0,     4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd0,     4'd1,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd255,   4'd2,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd255,   4'd4,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'hFFFF,  4'd15, 1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd256,   4'd8,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_READ,      16'hFFFF,  4'd0,  1'b1, 8'hFF,  48'd0},
    '{exh_pkg::MODE_READ,      16'd256,   4'd0,  1'b1, 8'd0,   48'd0},
    '{exh_pkg::MODE_READ,      16'd255,   4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd5,     4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_COUNT,     16'd5,     4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_TOP,       16'hFFFF,  4'd15, 1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_TOP,       16'd0,     4'd1,  1'b0, 8'd0,   48'd0},
    '{MODE_UNUSED_5,           16'd0,     4'd8,  1'b0, 8'd0,   48'd0},
    '{MODE_UNUSED_7,           16'hFFFF,  4'd15, 1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_CLEAR_ONE, 16'd255,   4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_CLEAR_ONE, 16'd300,   4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_READ,      16'd255,   4'd0,  1'b1, 8'd255, 48'd0},
    '{exh_pkg::MODE_TOP,       16'd0,     4'd3,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_CLEAR_ALL, 16'd0,     4'd0,  1'b0, 8'd0,   48'd0},
    '{exh_pkg::MODE_READ,      16'd0,     4'd0,  1'b1, 8'd0,   48'd0},
    '{exh_pkg::MODE_TOP,       16'd0,     4'd8,  1'b0, 8'd0,   48'd0}
  };

  exit_reason_histogram_top_k i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_reason       (in_reason),
    .in_top_count    (in_top_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reason_out  (out_reason_out),
    .out_event_count (out_event_count),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic predict_histogram_op(input logic [exh_pkg::MODE_W-1:0]      mode,
                                      input logic [exh_pkg::REASON_W-1:0]    reason,
                                      input logic [exh_pkg::TOP_COUNT_W-1:0] top);
    logic [exh_pkg::REASON_OUT_W-1:0] rank_reason [exh_pkg::TOP_MAX_DEF];
    logic [exh_pkg::EVENT_W-1:0]      rank_count [exh_pkg::TOP_MAX_DEF];
    bit                               in_range;
    int                               k;
    int                               slot;
    in_range = reason < exh_pkg::NUM_REASONS_DEF;
    case (mode)
      exh_pkg::MODE_COUNT: begin
        if (in_range && reason_tally[reason[7:0]] != '1) begin
          reason_tally[reason[7:0]] = reason_tally[reason[7:0]] +
                                      exh_pkg::COUNT_WIDTH_DEF'(1);
        end
      end
      exh_pkg::MODE_READ: begin
        pending_results.push_back(result_beat_t'{reason[exh_pkg::REASON_OUT_W-1:0],
            in_range ? reason_tally[reason[7:0]] : '0, 1'b1});
      end
      exh_pkg::MODE_CLEAR_ONE: begin
        if (in_range) begin
          reason_tally[reason[7:0]] = '0;
        end
      end
      exh_pkg::MODE_CLEAR_ALL: begin
        foreach (reason_tally[r]) reason_tally[r] = '0;
      end
      exh_pkg::MODE_TOP: begin
        k = (top > exh_pkg::TOP_MAX_DEF) ? exh_pkg::TOP_MAX_DEF : int'(top);
        foreach (rank_count[i]) begin
          rank_reason[i] = '0;
          rank_count[i] = '0;
        end
        for (int r = 0; r < exh_pkg::NUM_REASONS_DEF; r++) begin
          if (reason_tally[r] != 0) begin
            slot = k;
            for (int i = 0; i < k && slot == k; i++) begin
              if (reason_tally[r] > rank_count[i]) begin
                slot = i;
              end
            end
            if (slot < k) begin
              for (int j = k - 1; j > slot; j--) begin
                rank_reason[j] = rank_reason[j-1];
                rank_count[j] = rank_count[j-1];
              end
              rank_reason[slot] = r[exh_pkg::REASON_OUT_W-1:0];
              rank_count[slot] = reason_tally[r];
            end
          end
        end
        for (int i = 0; i < k; i++) begin
          pending_results.push_back(result_beat_t'{rank_reason[i], rank_count[i],
              i == k - 1});
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic drive_beat(input logic [exh_pkg::MODE_W-1:0]      mode,
                            input logic [exh_pkg::REASON_W-1:0]    reason,
                            input logic [exh_pkg::TOP_COUNT_W-1:0] top);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_reason    <= reason;
    in_top_count <= top;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: reason %0d count %0d",
                                    out_reason_out, out_event_count));
        end else begin
          oldest = pending_results.pop_front();
          if (out_reason_out !== oldest.reason) begin
            report_mismatch($sformatf("reason_out %0d, predicted %0d",
                                      out_reason_out, oldest.reason));
          end
          if (out_event_count !== oldest.count) begin
            report_mismatch($sformatf("event_count %0d, predicted %0d",
                                      out_event_count, oldest.count));
          end
          if (out_last !== oldest.is_last) begin
            report_mismatch($sformatf("last %0b, predicted %0b", out_last, oldest.is_last));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [exh_pkg::MODE_W-1:0]      mode;
    logic [exh_pkg::REASON_W-1:0]    reason;
    logic [exh_pkg::TOP_COUNT_W-1:0] top;
    int                              sel;
    int                              issued;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (reason_tally[r]) reason_tally[r] = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= exh_pkg::MODE_COUNT;
    in_reason    <= '0;
    in_top_count <= '0;
    out_stall    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      drive_beat(directed_rows[n].mode, directed_rows[n].reason, directed_rows[n].top);
      if (directed_rows[n].typed) begin
        pending_results.push_back(result_beat_t'{directed_rows[n].exp_reason,
            directed_rows[n].exp_count, 1'b1});
      end else begin
        predict_histogram_op(directed_rows[n].mode, directed_rows[n].reason,
                             directed_rows[n].top);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 36 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 36 : 0;
      hot_pool[0] = 8'd0;
      hot_pool[1] = 8'd255;
      for (int i = 2; i < HOT_POOL_SIZE; i++) hot_pool[i] = 8'($urandom_range(255));
      issued = 0;
      while (issued < RANDOM_ITEMS / 4) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          reason = exh_pkg::REASON_W'(
              hot_pool[$urandom_range($urandom_range(HOT_POOL_SIZE - 1))]);
        end else if (sel < 85) begin
          reason = exh_pkg::REASON_W'($urandom_range(exh_pkg::NUM_REASONS_DEF - 1));
        end else begin
          reason = exh_pkg::REASON_W'($urandom_range(16'hFFFF, exh_pkg::NUM_REASONS_DEF));
        end
        if ($urandom_range(9) == 0) begin
          top = exh_pkg::TOP_COUNT_W'($urandom_range(15));
        end else begin
          top = exh_pkg::TOP_COUNT_W'($urandom_range(exh_pkg::TOP_MAX_DEF, 1));
        end
        sel = $urandom_range(99);
        if (sel < 55) begin
          mode = exh_pkg::MODE_COUNT;
        end else if (sel < 70) begin
          mode = exh_pkg::MODE_READ;
        end else if (sel < 82) begin
          mode = exh_pkg::MODE_TOP;
        end else if (sel < 90) begin
          mode = exh_pkg::MODE_CLEAR_ONE;
        end else if (sel < 92) begin
          mode = exh_pkg::MODE_CLEAR_ALL;
        end else begin
          mode = exh_pkg::MODE_W'($urandom_range(MODE_UNUSED_7, MODE_UNUSED_5));
        end
        drive_beat(mode, reason, top);
        predict_histogram_op(mode, reason, top);
        issued++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted result beats never arrived",
                                pending_results.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
